// ===== rtl/olst_pkg.sv =====
// Shared types and codes for the ordered list store.
// No dependencies; the top and cell files use this package.
package olst_pkg;

  localparam int DATA_W    = 32;
  localparam int WIDX_W    = 9;   // wide enough for any cell index up to 256
  localparam int MEAN_W    = 44;
  localparam int FRAC_BITS = 8;

  localparam logic [2:0] FN_APPEND  = 3'd0;
  localparam logic [2:0] FN_PREPEND = 3'd1;
  localparam logic [2:0] FN_FIND    = 3'd2;
  localparam logic [2:0] FN_INSERT  = 3'd3;
  localparam logic [2:0] FN_AVERAGE = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_MERGE,
    S_DIV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_RIGHT,
    SH_LEFT
  } shift_t;

  typedef struct packed {
    shift_t                  shift;
    logic                    wr_en;
    logic [WIDX_W-1:0]       wr_idx;
    logic [DATA_W-1:0]       wr_data;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
    logic [4:0]               start_index;
  } in_beat_t;

  typedef struct packed {
    logic                     status;
    logic                     found;
    logic [3:0]               position;
    logic signed [MEAN_W-1:0] mean;
    logic [4:0]               length;
  } out_beat_t;

endpackage

// ===== rtl/olst_chan_if.sv =====
// Valid/ready channel carrying one payload beat.
// Payload type is a parameter; uses olst_pkg types at instantiation.
interface olst_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ordered_list_store_top.sv =====
// Ordered list store: controller, row of entry cells and mean divider.
// Depends on olst_pkg, olst_chan_if, olst_cell and olst_div.
//
//   channel   | dir | beat contents
//   ----------+-----+---------------------------------------------
//   in_chan   | in  | func, key, value, start_index
//   out_chan  | out | status, found, position, mean, length
//
// One beat in is handled at a time; it yields exactly one beat out.
// Append and prepend go straight to done. Find, insert and average on a
// non-empty list first rotate the whole list once; average then runs the
// divider of width 40+clog2(CAPACITY+1), insert merges on a hit or prepends on a miss.
// The rotate loop over the cell row sets find/insert/average timing.
// Reset (rst_n low, synchronous) empties the list; entry data is left as is.
// A result waiting on out_chan holds the block in its done state only
// until taken; a new beat is accepted as soon as the result is registered.
module ordered_list_store_top #(
  parameter int CAPACITY = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  olst_chan_if.sink                                 in_chan,
  olst_chan_if.source                               out_chan
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = olst_pkg::DATA_W + CNT_W;
  localparam int DIV_N = SUM_W + olst_pkg::FRAC_BITS;
  localparam int DW    = olst_pkg::DATA_W;

  olst_pkg::state_t     state_r, state_nxt;
  olst_pkg::in_beat_t   op_r, op_nxt;
  olst_pkg::out_beat_t  out_data_r, out_data_nxt;
  olst_pkg::cell_ctrl_t ctrl;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic [CNT_W-1:0]        p_r, p_nxt;
  logic [CNT_W-1:0]        hits_r, hits_nxt;
  logic [CNT_W-1:0]        hits_tot;
  logic                    found_r, found_nxt;
  logic [3:0]              pos_r, pos_nxt;
  logic                    status_r, status_nxt;
  logic                    ins_pend_r, ins_pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [olst_pkg::MEAN_W-1:0] mean_r, mean_nxt;
  logic                    neg_r, neg_nxt;

  logic [DW-1:0]           cell_q [CAPACITY];
  logic [DW-1:0]           head;
  logic                    match;
  logic                    last_k;
  logic                    accept;
  logic                    div_start;
  logic                    div_done;
  logic [DIV_N-1:0]        div_q;
  logic [SUM_W-1:0]        sum_abs;
  logic signed [DIV_N:0]   q_s;

  assign accept       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == olst_pkg::S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  assign head     = cell_q[0];
  assign match    = (head == op_r.key);
  assign last_k   = (k_r == cnt_r - 1'b1);
  assign hits_tot = hits_r + CNT_W'(match);

  // Cell row: each cell sees both neighbors, the ends see zero.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DW-1:0] left_q, right_q;
    if (g == 0) begin : g_l0
      assign left_q = '0;
    end else begin : g_ln
      assign left_q = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_rl
      assign right_q = '0;
    end else begin : g_rn
      assign right_q = cell_q[g+1];
    end
    olst_cell #(.CELL_IDX(g)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_q  (left_q),
      .right_q (right_q),
      .data_q  (cell_q[g])
    );
  end

  // The divider loads on the last scan cycle, so take the sum with the last entry added.
  assign sum_abs = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);

  olst_div #(.N(DIV_N), .D(CNT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_abs, {olst_pkg::FRAC_BITS{1'b0}}}),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_s = neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olst_pkg::S_IDLE: begin
        if (accept) begin
          if (cnt_r != '0 && (in_chan.data.func == olst_pkg::FN_FIND ||
              in_chan.data.func == olst_pkg::FN_INSERT ||
              in_chan.data.func == olst_pkg::FN_AVERAGE)) begin
            state_nxt = olst_pkg::S_SCAN;
          end else begin
            state_nxt = olst_pkg::S_DONE;
          end
        end
      end
      olst_pkg::S_SCAN: begin
        if (last_k) begin
          if (op_r.func == olst_pkg::FN_AVERAGE) begin
            state_nxt = olst_pkg::S_DIV;
          end else if (op_r.func == olst_pkg::FN_INSERT) begin
            if (hits_tot == '0) begin
              state_nxt = (cnt_r == CNT_W'(CAPACITY)) ? olst_pkg::S_DONE
                                                      : olst_pkg::S_PREP;
            end else if ((CNT_W+1)'(cnt_r) + (CNT_W+1)'(hits_tot) >
                         (CNT_W+1)'(CAPACITY)) begin
              state_nxt = olst_pkg::S_DONE;
            end else begin
              state_nxt = olst_pkg::S_MERGE;
            end
          end else begin
            state_nxt = olst_pkg::S_DONE;
          end
        end
      end
      olst_pkg::S_PREP: state_nxt = olst_pkg::S_DONE;
      olst_pkg::S_MERGE: begin
        if (ins_pend_r) begin
          if (k_r == cnt_r) state_nxt = olst_pkg::S_DONE;
        end else if (!match && last_k) begin
          state_nxt = olst_pkg::S_DONE;
        end
      end
      olst_pkg::S_DIV: begin
        if (div_done) state_nxt = olst_pkg::S_DONE;
      end
      olst_pkg::S_DONE: begin
        if (!out_valid_r || out_chan.ready) state_nxt = olst_pkg::S_IDLE;
      end
      default: state_nxt = olst_pkg::S_IDLE;
    endcase
  end

  // Datapath and cell control.
  always_comb begin
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    hits_nxt      = hits_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    status_nxt    = status_r;
    ins_pend_nxt  = ins_pend_r;
    sum_nxt       = sum_r;
    mean_nxt      = mean_r;
    neg_nxt       = neg_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ctrl.shift    = olst_pkg::SH_HOLD;
    ctrl.wr_en    = 1'b0;
    ctrl.wr_idx   = '0;
    ctrl.wr_data  = '0;

    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;

    case (state_r)
      olst_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt     = in_chan.data;
          k_nxt      = '0;
          p_nxt      = cnt_r;
          hits_nxt   = '0;
          found_nxt  = 1'b0;
          pos_nxt    = '0;
          status_nxt = 1'b0;
          sum_nxt    = '0;
          mean_nxt   = '0;
          ins_pend_nxt = 1'b0;
          case (in_chan.data.func)
            olst_pkg::FN_APPEND: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                status_nxt = 1'b1;
              end else begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_idx  = olst_pkg::WIDX_W'(cnt_r);
                ctrl.wr_data = in_chan.data.value;
                cnt_nxt      = cnt_r + 1'b1;
              end
            end
            olst_pkg::FN_PREPEND, olst_pkg::FN_INSERT: begin
              // insert into an empty list is a prepend; otherwise scan first
              if (in_chan.data.func == olst_pkg::FN_PREPEND || cnt_r == '0) begin
                if (cnt_r == CNT_W'(CAPACITY)) begin
                  status_nxt = 1'b1;
                end else begin
                  ctrl.shift   = olst_pkg::SH_RIGHT;
                  ctrl.wr_en   = 1'b1;
                  ctrl.wr_idx  = '0;
                  ctrl.wr_data = in_chan.data.value;
                  cnt_nxt      = cnt_r + 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      olst_pkg::S_SCAN: begin
        // rotate: head leaves cell 0 and re-enters at the tail
        ctrl.shift   = olst_pkg::SH_LEFT;
        ctrl.wr_en   = 1'b1;
        ctrl.wr_idx  = olst_pkg::WIDX_W'(cnt_r - 1'b1);
        ctrl.wr_data = head;
        hits_nxt     = hits_tot;
        sum_nxt      = sum_r + SUM_W'($signed(head));
        k_nxt        = k_r + 1'b1;
        if (op_r.func == olst_pkg::FN_FIND && match && !found_r &&
            10'(k_r) >= 10'(op_r.start_index)) begin
          found_nxt = 1'b1;
          pos_nxt   = 4'(k_r);
        end
        if (last_k) begin
          k_nxt = '0;
          if (op_r.func == olst_pkg::FN_AVERAGE) begin
            div_start = 1'b1;
            neg_nxt   = sum_nxt[SUM_W-1];
          end else if (op_r.func == olst_pkg::FN_INSERT) begin
            if (hits_tot == '0) begin
              if (cnt_r == CNT_W'(CAPACITY)) status_nxt = 1'b1;
            end else if ((CNT_W+1)'(cnt_r) + (CNT_W+1)'(hits_tot) >
                         (CNT_W+1)'(CAPACITY)) begin
              status_nxt = 1'b1;
            end
          end
        end
      end
      olst_pkg::S_PREP: begin
        ctrl.shift   = olst_pkg::SH_RIGHT;
        ctrl.wr_en   = 1'b1;
        ctrl.wr_idx  = '0;
        ctrl.wr_data = op_r.value;
        cnt_nxt      = cnt_r + 1'b1;
      end
      olst_pkg::S_MERGE: begin
        if (ins_pend_r) begin
          // drop the new value right after the matching entry
          ctrl.wr_en   = 1'b1;
          ctrl.wr_idx  = olst_pkg::WIDX_W'(p_r);
          ctrl.wr_data = op_r.value;
          p_nxt        = p_r + 1'b1;
          ins_pend_nxt = 1'b0;
          if (k_r == cnt_r) cnt_nxt = p_nxt;
        end else begin
          ctrl.shift   = olst_pkg::SH_LEFT;
          ctrl.wr_en   = 1'b1;
          ctrl.wr_idx  = olst_pkg::WIDX_W'(p_r - 1'b1);
          ctrl.wr_data = head;
          k_nxt        = k_r + 1'b1;
          ins_pend_nxt = match;
          if (!match && last_k) cnt_nxt = p_r;
        end
      end
      olst_pkg::S_DIV: begin
        if (div_done) mean_nxt = olst_pkg::MEAN_W'(q_s);
      end
      olst_pkg::S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.status   = status_r;
          out_data_nxt.found    = found_r;
          out_data_nxt.position = pos_r;
          out_data_nxt.mean     = mean_r;
          out_data_nxt.length   = 5'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olst_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      ins_pend_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ins_pend_r  <= ins_pend_nxt;
    end
    op_r       <= op_nxt;
    k_r        <= k_nxt;
    p_r        <= p_nxt;
    hits_r     <= hits_nxt;
    found_r    <= found_nxt;
    pos_r      <= pos_nxt;
    status_r   <= status_nxt;
    sum_r      <= sum_nxt;
    mean_r     <= mean_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  // Fill count never passes the cell row.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // Scan and merge only run over a non-empty list.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olst_pkg::S_SCAN || state_r == olst_pkg::S_MERGE) |-> cnt_r != '0)
    else $error("rotate on empty list");

  // Merge write pointer stays inside the row.
  a_merge_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olst_pkg::S_MERGE && ins_pend_r) |-> p_r < CNT_W'(CAPACITY))
    else $error("merge write beyond capacity");

  // A result is presented only after the done state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == olst_pkg::S_DONE)
    else $error("result raised outside done state");

endmodule

// ===== rtl/olst_cell.sv =====
// One storage cell of the list chain: holds one entry, takes a neighbor's.
// Depends on olst_pkg.
module olst_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                        clk,
  input  olst_pkg::cell_ctrl_t        ctrl,
  input  logic [olst_pkg::DATA_W-1:0] left_q,
  input  logic [olst_pkg::DATA_W-1:0] right_q,
  output logic [olst_pkg::DATA_W-1:0] data_q
);

  logic [olst_pkg::DATA_W-1:0] data_r;
  logic [olst_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.shift)
      olst_pkg::SH_RIGHT: data_nxt = left_q;
      olst_pkg::SH_LEFT:  data_nxt = right_q;
      default:            data_nxt = data_r;
    endcase
    // a direct write wins over the neighbor hand-off
    if (ctrl.wr_en && (ctrl.wr_idx == olst_pkg::WIDX_W'(CELL_IDX))) begin
      data_nxt = ctrl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// ===== rtl/olst_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle while busy.
// No package dependencies.
module olst_div #(
  parameter int N = 45,
  parameter int D = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic [D-1:0]  rem_r, rem_nxt;
  logic [N-1:0]  quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [D:0]    rem_sh;
  logic [D:0]    rem_sub;

  always_comb begin
    rem_sh   = {rem_r, quo_r[N-1]};
    rem_sub  = rem_sh - {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(N);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem_nxt = rem_sub[D-1:0];
        quo_nxt = {quo_r[N-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[D-1:0];
        quo_nxt = {quo_r[N-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
